// ===== design/twsc_pkg.sv =====
// Shared types, character codes and a helper function for the word and syllable counter.
package twsc_pkg;

  localparam int LETTER_BITS = 5;
  localparam int LEN_BITS    = 8;
  localparam int SYL_BITS    = 8;
  localparam int OUT_BITS    = 32;
  localparam int CLS_DEPTH   = 2;
  localparam int RES_DEPTH   = 2;

  typedef logic [LETTER_BITS-1:0] letter_t;

  // Letter codes: 1 for 'a' through 26 for 'z', 0 for an empty slot.
  localparam letter_t LTR_A = 5'd1;
  localparam letter_t LTR_C = 5'd3;
  localparam letter_t LTR_D = 5'd4;
  localparam letter_t LTR_E = 5'd5;
  localparam letter_t LTR_G = 5'd7;
  localparam letter_t LTR_I = 5'd9;
  localparam letter_t LTR_L = 5'd12;
  localparam letter_t LTR_O = 5'd15;
  localparam letter_t LTR_R = 5'd18;
  localparam letter_t LTR_S = 5'd19;
  localparam letter_t LTR_T = 5'd20;
  localparam letter_t LTR_U = 5'd21;
  localparam letter_t LTR_X = 5'd24;
  localparam letter_t LTR_Y = 5'd25;
  localparam letter_t LTR_Z = 5'd26;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // One classified byte as it travels from the front end to the word engine.
  typedef struct packed {
    logic    eot;
    logic    space;
    logic    term;
    logic    letter;
    logic    vowel;
    letter_t code;
  } cls_t;

  // One result as it waits for the consumer.
  typedef struct packed {
    logic [SYL_BITS-1:0] word_syllables;
    logic [OUT_BITS-1:0] words_total;
    logic [OUT_BITS-1:0] sentences_total;
    logic [OUT_BITS-1:0] syllables_total;
    logic                is_final;
  } res_t;

  function automatic logic is_vowel(input letter_t c);
    return (c == LTR_A) || (c == LTR_E) || (c == LTR_I) ||
           (c == LTR_O) || (c == LTR_U) || (c == LTR_Y);
  endfunction

endpackage

// ===== design/text_word_syllable_counter.sv =====
// Top level of the text word, sentence and syllable counter.
//
// Usage: text bytes enter through a queue-style port. A byte with its
// end_of_text flag is taken at a rising edge where push is high and full is
// low. Whitespace ends a word; each ended word produces one result carrying
// its syllable score and the running word, sentence and syllable totals.
// A request with end_of_text set always produces a final result (is_final
// high) and then returns every counter to zero.
// Results leave through a second queue: while empty is low the oldest result
// sits on the output ports, and it is taken at an edge where pop is high.
// Throughput is one byte per cycle while the output queue has room; the
// word engine takes a byte whenever the classification queue holds one.
// A request is first registered in the classification queue; the word
// engine then writes its result into the output queue for the consumer.
// When the consumer stalls, the output queue fills, the word engine holds,
// the classification queue fills and full rises; nothing is lost.
// Reset clears all queues, the word state and the totals.
module text_word_syllable_counter
  import twsc_pkg::*;
#(
  parameter int COUNT_BITS       = 32,
  parameter int MAX_WORD_LETTERS = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          char_byte_i,
  input  logic                end_of_text_i,
  output logic                empty,
  input  logic                pop,
  output logic [SYL_BITS-1:0] word_syllables_o,
  output logic [OUT_BITS-1:0] words_total_o,
  output logic [OUT_BITS-1:0] sentences_total_o,
  output logic [OUT_BITS-1:0] syllables_total_o,
  output logic                is_final_o
);

  cls_t cls_in, cls_head;
  logic cls_wr, cls_empty, cls_pop;
  res_t res_in, res_head;
  logic res_push, res_full;

  // Front end: classify each byte as it arrives.
  twsc_front u_front (
    .push_i        (push),
    .char_byte_i   (char_byte_i),
    .end_of_text_i (end_of_text_i),
    .wr_en_o       (cls_wr),
    .cls_o         (cls_in)
  );

  // Decoupling queue between classification and the word engine.
  twsc_fifo #(
    .item_t (cls_t),
    .DEPTH  (CLS_DEPTH)
  ) u_cls_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cls_wr),
    .wr_data_i (cls_in),
    .full_o    (full),
    .rd_en_i   (cls_pop),
    .rd_data_o (cls_head),
    .empty_o   (cls_empty)
  );

  // Word engine: per-byte update, scoring and saturating totals.
  twsc_back #(
    .COUNT_BITS       (COUNT_BITS),
    .MAX_WORD_LETTERS (MAX_WORD_LETTERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_head),
    .cls_empty_i (cls_empty),
    .cls_pop_o   (cls_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Output queue so the engine keeps working while a result waits.
  twsc_fifo #(
    .item_t (res_t),
    .DEPTH  (RES_DEPTH)
  ) u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_head),
    .empty_o   (empty)
  );

  assign word_syllables_o  = res_head.word_syllables;
  assign words_total_o     = res_head.words_total;
  assign sentences_total_o = res_head.sentences_total;
  assign syllables_total_o = res_head.syllables_total;
  assign is_final_o        = res_head.is_final;

endmodule

// ===== design/twsc_fifo.sv =====
// Small register-based first-in first-out queue used between the pipeline parts.
module twsc_fifo
  import twsc_pkg::*;
#(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_en_i,
  input  item_t wr_data_i,
  output logic  full_o,
  input  logic  rd_en_i,
  output item_t rd_data_o,
  output logic  empty_o
);

  // DEPTH must be at least two.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/twsc_front.sv =====
// Front end: sorts each incoming byte into whitespace, terminator, letter and vowel.
module twsc_front
  import twsc_pkg::*;
(
  input  logic       push_i,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_text_i,
  output logic       wr_en_o,
  output cls_t       cls_o
);

  logic is_upper, is_lower;

  assign is_upper = (char_byte_i >= CH_UPPER_A) && (char_byte_i <= CH_UPPER_Z);
  assign is_lower = (char_byte_i >= CH_LOWER_A) && (char_byte_i <= CH_LOWER_Z);

  always_comb begin
    cls_o.eot    = end_of_text_i;
    cls_o.space  = (char_byte_i == CH_SPACE) ||
                   ((char_byte_i >= CH_TAB) && (char_byte_i <= CH_CR));
    cls_o.term   = (char_byte_i == CH_DOT) || (char_byte_i == CH_BANG) ||
                   (char_byte_i == CH_QUEST);
    cls_o.letter = is_upper || is_lower;
    // The low five bits of an ASCII letter are its alphabet position in either case.
    cls_o.code   = cls_o.letter ? char_byte_i[LETTER_BITS-1:0] : '0;
    cls_o.vowel  = is_vowel(cls_o.code);
  end

  assign wr_en_o = push_i;

endmodule

// ===== design/twsc_back.sv =====
// Word engine: tracks the current word, scores syllables and keeps the running totals.
module twsc_back
  import twsc_pkg::*;
#(
  parameter int COUNT_BITS       = 32,
  parameter int MAX_WORD_LETTERS = 255
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cls_t cls_i,
  input  logic cls_empty_i,
  output logic cls_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_WORD_LETTERS);

  logic                  in_word_q, in_word_d;
  logic                  term_q, term_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic                  allv_q, allv_d;
  letter_t               recent_q [4];
  letter_t               recent_d [4];
  logic [SYL_BITS-1:0]   pair_q, pair_d;
  logic [COUNT_BITS-1:0] words_q, words_d;
  logic [COUNT_BITS-1:0] sents_q, sents_d;
  logic [COUNT_BITS-1:0] syls_q, syls_d;

  logic                  finish, emit;
  logic [SYL_BITS-1:0]   score;
  logic [COUNT_BITS-1:0] words_new, sents_new, syls_new;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [SYL_BITS-1:0]   b);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, a} + {{(COUNT_BITS + 1 - SYL_BITS){1'b0}}, b};
    if (sum[COUNT_BITS] || (&sum[COUNT_BITS-1:0])) begin
      return '1;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  // Syllable score of the word held in the state registers.
  always_comb begin
    letter_t    c0, c1, c2, c3;
    logic       ious, ier, ed_key, es_key, key, ending2;
    logic [1:0] fin;
    logic [9:0] s;
    c0 = recent_q[0];
    c1 = recent_q[1];
    c2 = recent_q[2];
    c3 = recent_q[3];
    ious = (len_q > 8'd4) && (c3 == LTR_I) && (c2 == LTR_O) && (c1 == LTR_U) &&
           (c0 == LTR_S);
    ier  = (len_q > 8'd3) && (c2 == LTR_I) && (c1 == LTR_E) && (c0 == LTR_R);
    ed_key = (c1 == LTR_E) && (c0 == LTR_D) &&
             !((c2 == LTR_D) || (c2 == LTR_T)) &&
             !((c2 == LTR_R) && (len_q > 8'd3) && (c3 != LTR_R)) &&
             !((c2 == LTR_L) && (len_q > 8'd3) && !is_vowel(c3));
    es_key = (c1 == LTR_E) && (c0 == LTR_S) && (len_q > 8'd3) &&
             !((c2 == LTR_C) || (c2 == LTR_G) || (c2 == LTR_X) ||
               (c2 == LTR_S) || (c2 == LTR_Z)) &&
             ((c2 != LTR_L) || ((len_q > 8'd4) && is_vowel(c3)));
    key = (len_q > 8'd2) && (ed_key || es_key);
    ending2 = ((c1 == LTR_E) && (c0 == LTR_A)) || ((c1 == LTR_I) && (c0 == LTR_I)) ||
              ((c1 == LTR_I) && (c0 == LTR_O)) || ((c1 == LTR_U) && (c0 == LTR_A)) ||
              ((c1 == LTR_U) && (c0 == LTR_O));
    priority if (len_q == 8'd1) begin
      fin = is_vowel(c0) ? 2'd1 : 2'd0;
    end else if (!is_vowel(c0) || ((c0 == LTR_E) && !is_vowel(c1))) begin
      fin = 2'd0;
    end else if (ending2) begin
      fin = 2'd2;
    end else begin
      fin = 2'd1;
    end
    s = {2'b00, pair_q} + 10'(ious) + 10'(ier) + 10'(fin) - 10'(key);
    priority if (len_q == '0) begin
      score = '0;
    end else if (allv_q) begin
      score = len_q;
    end else if (s[9] || (s == '0)) begin
      score = 8'd1;
    end else if (s[8]) begin
      score = '1;
    end else begin
      score = s[7:0];
    end
  end

  assign cls_pop_o  = !cls_empty_i && !res_full_i;
  assign finish     = cls_pop_o && in_word_q && (cls_i.eot || cls_i.space);
  assign emit       = cls_pop_o && (cls_i.eot || (cls_i.space && in_word_q));
  assign res_push_o = emit;

  assign words_new = finish ? sat_add(words_q, 8'd1) : words_q;
  assign sents_new = (finish && term_q) ? sat_add(sents_q, 8'd1) : sents_q;
  assign syls_new  = finish ? sat_add(syls_q, score) : syls_q;

  always_comb begin
    res_o.word_syllables  = finish ? score : '0;
    res_o.words_total     = OUT_BITS'(words_new);
    res_o.sentences_total = OUT_BITS'(sents_new);
    res_o.syllables_total = OUT_BITS'(syls_new);
    res_o.is_final        = cls_i.eot;
  end

  // Next word state.
  always_comb begin
    logic [1:0]          add;
    logic [SYL_BITS:0]   pair_sum;
    add       = '0;
    pair_sum  = '0;
    in_word_d = in_word_q;
    term_d    = term_q;
    len_d     = len_q;
    allv_d    = allv_q;
    pair_d    = pair_q;
    recent_d  = recent_q;
    words_d   = words_new;
    sents_d   = sents_new;
    syls_d    = syls_new;
    if (cls_pop_o) begin
      priority if (cls_i.eot || cls_i.space) begin
        in_word_d = 1'b0;
        term_d    = 1'b0;
        len_d     = '0;
        allv_d    = 1'b1;
        pair_d    = '0;
        recent_d  = '{default: '0};
        if (cls_i.eot) begin
          words_d = '0;
          sents_d = '0;
          syls_d  = '0;
        end
      end else begin
        in_word_d = 1'b1;
        term_d    = term_q || cls_i.term;
        if (cls_i.letter) begin
          if (len_q != '0) begin
            add = 2'(is_vowel(recent_q[0]) && !cls_i.vowel) +
                  2'((recent_q[0] == LTR_I) && (cls_i.code == LTR_A)) +
                  2'((recent_q[0] == LTR_E) && (cls_i.code == LTR_O));
            pair_sum = {1'b0, pair_q} + {{(SYL_BITS - 1){1'b0}}, add};
            pair_d   = pair_sum[SYL_BITS] ? '1 : pair_sum[SYL_BITS-1:0];
          end
          recent_d[3] = recent_q[2];
          recent_d[2] = recent_q[1];
          recent_d[1] = recent_q[0];
          recent_d[0] = cls_i.code;
          if (len_q < LEN_MAX) begin
            len_d = len_q + 1'b1;
          end
          allv_d = allv_q && cls_i.vowel;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      term_q    <= 1'b0;
      len_q     <= '0;
      allv_q    <= 1'b1;
      pair_q    <= '0;
      recent_q  <= '{default: '0};
      words_q   <= '0;
      sents_q   <= '0;
      syls_q    <= '0;
    end else begin
      in_word_q <= in_word_d;
      term_q    <= term_d;
      len_q     <= len_d;
      allv_q    <= allv_d;
      pair_q    <= pair_d;
      recent_q  <= recent_d;
      words_q   <= words_d;
      sents_q   <= sents_d;
      syls_q    <= syls_d;
    end
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the text word, sentence and syllable counter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twsc_pkg::*;

  // Bytes that the package does not name but that the stimulus needs.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Saturation points of the word scoring and of the totals.
  localparam int          LETTER_CAP = 255;
  localparam int          PAIR_CAP   = 255;
  localparam int          SCORE_CAP  = 255;
  localparam logic [31:0] TOTAL_CAP  = 32'hFFFF_FFFF;

  // The tail wait after the last result is generous.
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 250;
  localparam int TIMEOUT_NS   = 2_000_000;

  // One text request waiting for the driver.
  typedef struct {
    logic [7:0] ch;
    logic       eot;
  } text_req_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic       pop           = 1'b0;
  logic [7:0] char_byte_i   = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       full;
  logic       empty;
  logic [SYL_BITS-1:0] word_syllables_o;
  logic [OUT_BITS-1:0] words_total_o;
  logic [OUT_BITS-1:0] sentences_total_o;
  logic [OUT_BITS-1:0] syllables_total_o;
  logic                is_final_o;

  text_word_syllable_counter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .char_byte_i      (char_byte_i),
    .end_of_text_i    (end_of_text_i),
    .empty            (empty),
    .pop              (pop),
    .word_syllables_o (word_syllables_o),
    .words_total_o    (words_total_o),
    .sentences_total_o(sentences_total_o),
    .syllables_total_o(syllables_total_o),
    .is_final_o       (is_final_o)
  );

  // Requests not yet accepted, and the results that accepted requests owe.
  text_req_t text_q[$];
  res_t      totals_q[$];

  // Idle control. A percentage of zero means no idle bursts on that side.
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int tx_gap_left  = 0;
  int rx_gap_left  = 0;
  int rx_hold_left = 0;

  int mismatch_cnt = 0;
  int result_idx   = 0;
  int queued_cnt   = 0;

  // Predictor state: the word being collected and the running totals.
  logic        word_open      = 1'b0;
  logic        word_has_term  = 1'b0;
  logic        word_all_vowel = 1'b1;
  int          word_letters   = 0;
  int          word_pairs     = 0;
  letter_t     tail_ltr [4]   = '{default: '0};
  logic [31:0] word_cnt       = '0;
  logic [31:0] sentence_cnt   = '0;
  logic [31:0] syllable_cnt   = '0;

  string vowel_set    = "aeiouy";
  string alphabet_set = "abcdefghijklmnopqrstuvwxyz";
  logic [7:0] blank_pool [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  // Endings that steer the suffix rules and the final-letter term.
  string suffix_pool[$] = '{"ious", "ier", "ed", "es", "ted", "ded", "red", "rred",
                            "led", "aled", "ces", "ges", "xes", "ses", "zes", "les",
                            "ales", "ea", "ii", "io", "ua", "uo", "e", "ia", "eo", "y"};

  // Words that walk through every scoring rule at least once.
  string directed_words[$] = '{"a", "aeiouy", "cat", "curious", "happier", "wanted",
                               "jumped", "hired", "barred", "fled", "sailed", "bed",
                               "red", "led", "faces", "tables", "males", "ales",
                               "makes", "radii", "patio", "duo", "rule", "toe",
                               "piano", "people", "RHYTHM", "HeLLo", "end.", "what?!",
                               "...", "ioUs"};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic blank_byte(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic vowel_ltr(input letter_t c);
    return (c == LTR_A) || (c == LTR_E) || (c == LTR_I) ||
           (c == LTR_O) || (c == LTR_U) || (c == LTR_Y);
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input int unsigned b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return (s > {1'b0, TOTAL_CAP}) ? TOTAL_CAP : s[31:0];
  endfunction

  // Syllable score of the word held in the predictor state.
  function automatic logic [7:0] score_word();
    letter_t c0, c1, c2, c3;
    int      n, s, fin;
    logic    cut;
    n = word_letters;
    if (n == 0) return 8'd0;
    if (word_all_vowel) return 8'((n > SCORE_CAP) ? SCORE_CAP : n);
    c0 = tail_ltr[0];
    c1 = tail_ltr[1];
    c2 = tail_ltr[2];
    c3 = tail_ltr[3];
    s = word_pairs;
    if (n > 4 && c3 == LTR_I && c2 == LTR_O && c1 == LTR_U && c0 == LTR_S) s++;
    if (n > 3 && c2 == LTR_I && c1 == LTR_E && c0 == LTR_R) s++;
    cut = 1'b0;
    if (n > 2) begin
      // An "ed" ending is usually silent; each exception is decided on its own.
      if (c1 == LTR_E && c0 == LTR_D) begin
        cut = 1'b1;
        if (c2 == LTR_D || c2 == LTR_T) begin
          cut = 1'b0;
        end else if (c2 == LTR_R) begin
          if (n > 3 && c3 != LTR_R) cut = 1'b0;
        end else if (c2 == LTR_L) begin
          if (n > 3 && !vowel_ltr(c3)) cut = 1'b0;
        end
      end else if (c1 == LTR_E && c0 == LTR_S && n > 3) begin
        if (c2 == LTR_C || c2 == LTR_G || c2 == LTR_X || c2 == LTR_S || c2 == LTR_Z) begin
          cut = 1'b0;
        end else if (c2 == LTR_L) begin
          if (n > 4) cut = vowel_ltr(c3);
        end else begin
          cut = 1'b1;
        end
      end
      if (cut) s--;
    end
    // Final-letter term; -1 marks "not decided yet".
    fin = -1;
    if (n > 1) begin
      if ((c1 == LTR_E && c0 == LTR_A) || (c1 == LTR_I && c0 == LTR_I) ||
          (c1 == LTR_I && c0 == LTR_O) || (c1 == LTR_U && c0 == LTR_A) ||
          (c1 == LTR_U && c0 == LTR_O)) begin
        fin = 2;
      end else begin
        fin = 1;
      end
    end
    if (c0 == LTR_E && n > 1 && !vowel_ltr(c1)) fin = 0;
    if (!vowel_ltr(c0)) fin = 0;
    if (fin == -1) fin = 1;
    s += fin;
    if (s < 1) s = 1;
    if (s > SCORE_CAP) s = SCORE_CAP;
    return 8'(s);
  endfunction

  // Advances the predictor by one accepted request and queues what it owes.
  task automatic count_byte(input logic [7:0] b, input logic eot);
    res_t        owed;
    logic [7:0]  syl;
    logic [7:0]  low;
    letter_t     code;
    int          add;
    if (eot || blank_byte(b)) begin
      // Whitespace or end of text closes a pending word.
      syl = 8'd0;
      if (word_open) begin
        syl = score_word();
        word_cnt = sat_add(word_cnt, 1);
        if (word_has_term) sentence_cnt = sat_add(sentence_cnt, 1);
        syllable_cnt = sat_add(syllable_cnt, 32'(syl));
      end
      if (eot || word_open) begin
        owed.word_syllables  = syl;
        owed.words_total     = word_cnt;
        owed.sentences_total = sentence_cnt;
        owed.syllables_total = syllable_cnt;
        owed.is_final        = eot;
        totals_q.push_back(owed);
      end
      word_open      = 1'b0;
      word_has_term  = 1'b0;
      word_all_vowel = 1'b1;
      word_letters   = 0;
      word_pairs     = 0;
      tail_ltr       = '{default: '0};
      if (eot) begin
        word_cnt     = '0;
        sentence_cnt = '0;
        syllable_cnt = '0;
      end
    end else begin
      word_open = 1'b1;
      if (b == CH_DOT || b == CH_BANG || b == CH_QUEST) word_has_term = 1'b1;
      if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z)) begin
        low  = (b <= CH_UPPER_Z) ? b + CASE_GAP : b;
        code = letter_t'(low - CH_LOWER_A + 8'd1);
        if (word_letters > 0) begin
          add = 0;
          if (vowel_ltr(tail_ltr[0]) && !vowel_ltr(code)) add++;
          if (tail_ltr[0] == LTR_I && code == LTR_A) add++;
          if (tail_ltr[0] == LTR_E && code == LTR_O) add++;
          word_pairs = (word_pairs + add > PAIR_CAP) ? PAIR_CAP : word_pairs + add;
        end
        tail_ltr[3] = tail_ltr[2];
        tail_ltr[2] = tail_ltr[1];
        tail_ltr[1] = tail_ltr[0];
        tail_ltr[0] = code;
        if (word_letters < LETTER_CAP) word_letters++;
        if (!vowel_ltr(code)) word_all_vowel = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Every failure goes through here: one line in the log and one more count.
  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    $display("%0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                              result_idx, name, got, want));
    end
  endtask

  // The monitor looks at both handshakes at the rising edge. Results are
  // checked before the request of the same edge enters the predictor, since
  // no result can answer a request in the cycle that it is accepted.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (totals_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", result_idx));
        end else begin
          want = totals_q.pop_front();
          check_field("word_syllables", 32'(word_syllables_o), 32'(want.word_syllables));
          check_field("words_total", words_total_o, want.words_total);
          check_field("sentences_total", sentences_total_o, want.sentences_total);
          check_field("syllables_total", syllables_total_o, want.syllables_total);
          check_field("is_final", 32'(is_final_o), 32'(want.is_final));
        end
        result_idx++;
      end
      if (push && !full) begin
        count_byte(char_byte_i, end_of_text_i);
        if (text_q.size() > 0) text_q.delete(0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both acting on the falling edge
  // ---------------------------------------------------------------------------

  // The driver offers the oldest pending request unless it is in an idle
  // burst. A request refused because full was high stays at the head of the
  // queue and is offered again.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (tx_gap_left > 0) begin
      tx_gap_left--;
      push <= 1'b0;
    end else if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      tx_gap_left = $urandom_range(0, 12);
      push <= 1'b0;
    end else if (text_q.size() > 0) begin
      push          <= 1'b1;
      char_byte_i   <= text_q[0].ch;
      end_of_text_i <= text_q[0].eot;
    end else begin
      push <= 1'b0;
    end
  end

  // The receiver stalls in random bursts, and counts down a long hold-off
  // when the stimulus asks for one so that the block backs up to its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      pop <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      pop <= 1'b0;
    end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap_left = $urandom_range(0, 12);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b, input logic eot);
    text_req_t req;
    req.ch  = b;
    req.eot = eot;
    text_q.push_back(req);
    queued_cnt++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  task automatic put_blank();
    put_byte(blank_pool[$urandom_range(0, 5)], 1'b0);
  endtask

  // One letter, biased toward vowels so that the pair rules fire often,
  // and sometimes in upper case.
  task automatic put_letter();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 4) b = vowel_set[$urandom_range(0, 5)];
    else b = alphabet_set[$urandom_range(0, 25)];
    if ($urandom_range(0, 4) == 0) b = b - CASE_GAP;
    put_byte(b, 1'b0);
  endtask

  // A word of random letters, often with a suffix that the scoring treats
  // specially. With odd set, non-blank bytes of any value are mixed in.
  task automatic put_random_word(input logic odd);
    int         len;
    int         start;
    logic [7:0] b;
    start = queued_cnt;
    len   = $urandom_range(0, 6);
    for (int k = 0; k < len; k++) begin
      if (odd && $urandom_range(0, 2) == 0) begin
        do b = 8'($urandom_range(0, 255)); while (blank_byte(b));
        put_byte(b, 1'b0);
      end
      put_letter();
    end
    if ($urandom_range(0, 1) == 1) put_text(suffix_pool[$urandom_range(0, suffix_pool.size() - 1)]);
    if (queued_cnt == start) put_letter();
    case ($urandom_range(0, 11))
      0: put_byte(CH_DOT, 1'b0);
      1: put_byte(CH_BANG, 1'b0);
      2: put_byte(CH_QUEST, 1'b0);
      default: ;
    endcase
    repeat ($urandom_range(1, 2)) put_blank();
  endtask

  // Random text: mostly words, some loose bytes and an occasional end of text
  // that carries an arbitrary byte which the block must ignore.
  task automatic put_random_text(input int budget);
    int start;
    int pick;
    start = queued_cnt;
    while (queued_cnt - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 76) put_random_word(1'b0);
      else if (pick < 88) put_random_word(1'b1);
      else if (pick < 96) put_byte(8'($urandom_range(0, 255)), 1'b0);
      else put_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic wait_sent();
    while (text_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (text_q.size() != 0 || totals_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. End of text straight after reset owes a final result
    // with nothing in it.
    put_byte(8'($urandom_range(0, 255)), 1'b1);
    foreach (directed_words[i]) begin
      put_text(directed_words[i]);
      put_byte(blank_pool[i % 6], 1'b0);
    end
    // Bytes of zero and from 128 up belong to words; a run of blanks ends
    // only one word.
    put_text("x");
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h80, 1'b0);
    put_text("y");
    put_blank();
    put_blank();
    put_blank();
    // End of text with a word pending, then again with nothing pending.
    put_text("pending");
    put_byte(CH_SPACE, 1'b1);
    put_byte(CH_LOWER_A, 1'b1);

    // The sender pauses here until every owed result has come back.
    wait_drained();

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the output side fills and full must rise.
    rx_hold_left = HOLD_CYCLES;
    put_random_text(40);
    wait_drained();

    tx_idle_pct = 8;
    rx_idle_pct = 8;
    put_random_text(60);
    // A word long enough to saturate the letter count, the pair count and
    // the score, then an all-vowel word past the letter limit.
    for (int k = 0; k < 130; k++) put_text("iab");
    put_blank();
    for (int k = 0; k < 258; k++) put_byte(vowel_set[k % 6], 1'b0);
    put_blank();
    wait_sent();

    tx_idle_pct = 25;
    rx_idle_pct = 0;
    put_random_text(40);
    wait_sent();

    tx_idle_pct = 0;
    rx_idle_pct = 25;
    put_random_text(30);
    wait_sent();

    // The last part runs with no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    tx_gap_left = 0;
    rx_gap_left = 0;
    put_random_text(40);
    put_byte(8'($urandom_range(0, 255)), 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
